/* src/firc_pkg.sv */
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, default sizes, function codes and the control word that the top
// level hands to each delay-line cell.
// ----------------------------------------------------------------------------
package firc_pkg;

  localparam int DATA_W       = 16;  // sample and coefficient width
  localparam int ACC_W        = 32;  // product and sum width
  localparam int CFG_W        = 6;   // width of the tap count register
  localparam int COEF_IDX_W   = 5;   // width of the coefficient index field
  localparam int MAX_TAPS_DEF = 32;  // default delay line length

  localparam logic [CFG_W-1:0] TAPS_RESET = CFG_W'(32);

  // Function codes carried by the func field of an input word.
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Per-cell control: load takes the new sample, shift takes the neighbour.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/firc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module firc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/firc_cell.sv */
// ----------------------------------------------------------------------------
// Delay-line cell
// Holds one sample; takes a new sample or its neighbour's value on command.
// ----------------------------------------------------------------------------
module firc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  firc_pkg::cell_ctrl_t           ctrl,
  input  logic [firc_pkg::DATA_W-1:0]    load_data,
  input  logic [firc_pkg::DATA_W-1:0]    neighbour,
  output logic [firc_pkg::DATA_W-1:0]    value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.load) begin
      value <= load_data;
    end else if (ctrl.shift) begin
      value <= neighbour;
    end
  end

endmodule

/* src/firc_mac.sv */
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// A registered 16x16 signed product followed by a wrapping 32-bit accumulator.
// ----------------------------------------------------------------------------
module firc_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               mul_en,
  input  logic signed [firc_pkg::DATA_W-1:0] coef,
  input  logic signed [firc_pkg::DATA_W-1:0] sample,
  output logic                               busy,
  output logic signed [firc_pkg::ACC_W-1:0]  acc
);

  logic signed [firc_pkg::ACC_W-1:0] prod_full;
  logic signed [firc_pkg::ACC_W-1:0] prod_q;

  assign prod_full = firc_pkg::ACC_W'(coef) * firc_pkg::ACC_W'(sample);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_q <= prod_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      acc  <= '0;
    end else begin
      busy <= mul_en;
      if (clear) begin
        acc <= '0;
      end else if (busy) begin
        acc <= acc + prod_q;
      end
    end
  end

endmodule

/* src/fir_filter_circular_unit.sv */
// ----------------------------------------------------------------------------
// FIR filter with circular delay line
// Direct-form FIR filter: a ring of sample cells, a coefficient RAM and one
// multiply-accumulate unit that walks the taps one per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-----------------------------
//  config   | in        | cfg_we                   | cfg_wdata (tap count)
//  input    | in        | in_valid / in_stall      | func, sample, coef_index,
//           |           |                          | coef_value
//  output   | out       | out_valid / out_stall    | filtered
//
// A coefficient load word does not stall the input and gives no output word.
// For a sample word the single multiplier sees one tap per cycle; each tap
// passes through the coefficient RAM read stage and the product register
// before it is added to the sum, and the next word is accepted only after
// the result is registered. Reset (synchronous, active high) clears the
// delay line, the write position, the output valid flag and sets the tap
// count to 32; coefficients are not cleared. A stalled output word holds;
// the next word can still be accepted and computed, and its result waits
// in the pipeline until the output is free.
//
// The delay line is a ring of cells. While a sample word is worked on, the
// ring of the first T cells rotates by one position each cycle, so cell 0
// presents every stored sample in turn; after T shifts the ring is back in
// its original order. The coefficient address starts at T-1-pos and steps
// round modulo T alongside it.
// ----------------------------------------------------------------------------
module fir_filter_circular_unit #(
  parameter int MAX_TAPS = firc_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [firc_pkg::CFG_W-1:0]            cfg_wdata,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic signed [firc_pkg::DATA_W-1:0]    sample,
  input  logic [firc_pkg::COEF_IDX_W-1:0]       coef_index,
  input  logic signed [firc_pkg::DATA_W-1:0]    coef_value,
  // output words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [firc_pkg::ACC_W-1:0]     filtered
);

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int DW    = firc_pkg::DATA_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Control registers.
  state_t                   state;
  logic [firc_pkg::CFG_W-1:0] num_taps;
  logic [IDX_W-1:0]         write_pos;
  logic [CNT_W-1:0]         taps_q;
  logic [CNT_W-1:0]         issue_cnt;
  logic [IDX_W-1:0]         caddr;
  logic                     rd_v;

  // Payload registers.
  logic [DW-1:0]            head_q;

  // Combinational helpers.
  logic                     accept;
  logic                     acc_sample;
  logic                     acc_load;
  logic                     load_ok;
  logic [CNT_W-1:0]         taps_eff;
  logic [IDX_W-1:0]         pos_eff;
  logic [CNT_W-1:0]         pos_inc;
  logic [IDX_W-1:0]         pos_next;
  logic [IDX_W-1:0]         caddr_start;
  logic [CNT_W-1:0]         caddr_inc;
  logic [IDX_W-1:0]         caddr_next;
  logic                     issuing;
  logic                     drained;
  logic                     out_free;
  logic                     done;

  logic [DW-1:0]            ram_rdata;
  logic                     mac_busy;
  logic signed [firc_pkg::ACC_W-1:0] mac_acc;

  logic [DW-1:0]            cell_q [MAX_TAPS];

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign acc_sample = accept && (func == firc_pkg::FUNC_FILTER);
  assign acc_load   = accept && (func == firc_pkg::FUNC_LOAD);
  assign load_ok    = 32'(coef_index) < 32'(MAX_TAPS);

  // Effective tap count: zero acts as one, anything above the line length
  // acts as the full line.
  always_comb begin
    if (num_taps == '0) begin
      taps_eff = CNT_W'(1);
    end else if (32'(num_taps) > 32'(MAX_TAPS)) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(num_taps);
    end
  end

  // If the tap count shrank to or below the write position, writing restarts at 0.
  always_comb begin
    pos_eff     = (CNT_W'(write_pos) >= taps_eff) ? '0 : write_pos;
    pos_inc     = CNT_W'(pos_eff) + CNT_W'(1);
    pos_next    = (pos_inc >= taps_eff) ? '0 : IDX_W'(pos_inc);
    caddr_start = IDX_W'(taps_eff - CNT_W'(1) - CNT_W'(pos_eff));
    caddr_inc   = CNT_W'(caddr) + CNT_W'(1);
    caddr_next  = (caddr_inc >= taps_q) ? '0 : IDX_W'(caddr_inc);
  end

  assign issuing  = (state == ST_RUN) && (issue_cnt < taps_q);
  assign drained  = (issue_cnt == taps_q) && !rd_v && !mac_busy;
  assign out_free = !out_valid || !out_stall;
  // The sum is complete and the output register can take it.
  assign done     = (state == ST_RUN) && drained && out_free;

  // Control sequence and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      num_taps  <= firc_pkg::TAPS_RESET;
      write_pos <= '0;
      taps_q    <= CNT_W'(1);
      issue_cnt <= '0;
      caddr     <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_taps <= cfg_wdata;
      end
      rd_v <= issuing;
      // A new result replaces the old word in the same cycle it is taken.
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc_sample) begin
            write_pos <= pos_next;
            taps_q    <= taps_eff;
            issue_cnt <= '0;
            caddr     <= caddr_start;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
            caddr     <= caddr_next;
          end
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      filtered <= mac_acc;
    end
    if (issuing) begin
      head_q <= cell_q[0];
    end
  end

  // Coefficient table.
  firc_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (acc_load && load_ok),
    .waddr (IDX_W'(coef_index)),
    .wdata (coef_value),
    .re    (issuing),
    .raddr (caddr),
    .rdata (ram_rdata)
  );

  // Ring of delay-line cells. Cell T-1 takes its value from cell 0; cells at
  // or beyond T keep their contents.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int NEXT = (i + 1) % MAX_TAPS;
    firc_pkg::cell_ctrl_t ctrl;
    logic [DW-1:0]        nb;

    assign ctrl.load  = acc_sample && (pos_eff == IDX_W'(i));
    assign ctrl.shift = issuing && (CNT_W'(i) < taps_q);
    assign nb         = (CNT_W'(i) == taps_q - CNT_W'(1)) ? cell_q[0] : cell_q[NEXT];

    firc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .load_data (sample),
      .neighbour (nb),
      .value     (cell_q[i])
    );
  end

  firc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (acc_sample),
    .mul_en (rd_v),
    .coef   ($signed(ram_rdata)),
    .sample ($signed(head_q)),
    .busy   (mac_busy),
    .acc    (mac_acc)
  );

endmodule

/* src/firc_checker.sv */
// ----------------------------------------------------------------------------
// FIR filter port checker
// Watches the top-level ports and flags handshake and sequencing faults.
// ----------------------------------------------------------------------------
module firc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               func,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [firc_pkg::ACC_W-1:0]  filtered
);

  // A stalled output word stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered))
    else $error("output word changed or dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A coefficient load does not stall the input after it is accepted.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == firc_pkg::FUNC_LOAD) |=> !in_stall)
    else $error("input stalled after a coefficient load");

  // A sample word occupies the block.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == firc_pkg::FUNC_FILTER) |=> in_stall)
    else $error("input not stalled while a sample is filtered");

  // A new result only appears at the end of a sample's work.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

endmodule

bind fir_filter_circular_unit firc_checker u_firc_checker (.*);
